>>> hdl/irdv_pkg.sv
package irdv_pkg;

  // Field widths of the sample and result beats
  localparam int PIN_COUNT  = 12;
  localparam int SENSOR_W   = 4;
  localparam int VALUE_W    = 17;
  localparam int POWER_W    = 35;
  localparam int COUNT_W    = 6;
  localparam int WEIGHT_W   = 16;
  localparam int PROD_W     = 32;

  // Low time above this always gives the saturated value 131071
  localparam int CLAMP_W = 21;
  localparam logic [CLAMP_W-1:0] LOW_CLAMP = 21'd1703935;

  // floor(x / 13) == (x * RECIP_13) >> RECIP_SHIFT for every x below 2^21
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 25;
  localparam logic [RECIP_W-1:0] RECIP_13 = 22'd2581111;

  // Saturation limits of the direction sums
  localparam logic signed [POWER_W:0] SUM_MAX = 36'sd17179869183;
  localparam logic signed [POWER_W:0] SUM_MIN = -36'sd17179869184;

  // Register map
  localparam logic [5:0] CHANGES_RESET = 6'd10;
  localparam logic       REG_CHANGES   = 1'b0;

  // Sensor finished in the measure stage
  typedef struct packed {
    logic [SENSOR_W-1:0] sensor;
    logic                done;
    logic [CLAMP_W-1:0]  low_time;
  } finish_t;

  // Sensor value after the divide by 13
  typedef struct packed {
    logic [SENSOR_W-1:0] sensor;
    logic                done;
    logic [VALUE_W-1:0]  value;
  } value_t;

  // Sensor value with its weighted terms
  typedef struct packed {
    logic [SENSOR_W-1:0]      sensor;
    logic                     done;
    logic [VALUE_W-1:0]       value;
    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
  } term_t;

  // Ring position reduced to the twelve 30 degree angles
  function automatic logic [SENSOR_W-1:0] angle_of(input logic [SENSOR_W-1:0] s);
    angle_of = (s >= 4'd12) ? s - 4'd12 : s;
  endfunction

  // cos(30 deg * k) in Q1.14
  function automatic logic signed [WEIGHT_W-1:0] cos_weight(input logic [SENSOR_W-1:0] s);
    case (angle_of(s))
      4'd0:    cos_weight = 16'sd16384;
      4'd1:    cos_weight = 16'sd14189;
      4'd2:    cos_weight = 16'sd8192;
      4'd3:    cos_weight = 16'sd0;
      4'd4:    cos_weight = -16'sd8192;
      4'd5:    cos_weight = -16'sd14189;
      4'd6:    cos_weight = -16'sd16384;
      4'd7:    cos_weight = -16'sd14189;
      4'd8:    cos_weight = -16'sd8192;
      4'd9:    cos_weight = 16'sd0;
      4'd10:   cos_weight = 16'sd8192;
      4'd11:   cos_weight = 16'sd14189;
      default: cos_weight = 16'sd0;
    endcase
  endfunction

  // sin(30 deg * k) in Q1.14
  function automatic logic signed [WEIGHT_W-1:0] sin_weight(input logic [SENSOR_W-1:0] s);
    case (angle_of(s))
      4'd0:    sin_weight = 16'sd0;
      4'd1:    sin_weight = 16'sd8192;
      4'd2:    sin_weight = 16'sd14189;
      4'd3:    sin_weight = 16'sd16384;
      4'd4:    sin_weight = 16'sd14189;
      4'd5:    sin_weight = 16'sd8192;
      4'd6:    sin_weight = 16'sd0;
      4'd7:    sin_weight = -16'sd8192;
      4'd8:    sin_weight = -16'sd14189;
      4'd9:    sin_weight = -16'sd16384;
      4'd10:   sin_weight = -16'sd14189;
      4'd11:   sin_weight = -16'sd8192;
      default: sin_weight = 16'sd0;
    endcase
  endfunction

endpackage

>>> hdl/irdv_if.sv
interface irdv_sample_if;
  import irdv_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [PIN_COUNT-1:0] pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface

interface irdv_result_if;
  import irdv_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [SENSOR_W-1:0]       sensor_index;
  logic [VALUE_W-1:0]        sensor_value;
  logic                      scan_done;
  logic signed [POWER_W-1:0] power_x;
  logic signed [POWER_W-1:0] power_y;

  modport source (output valid, output sensor_index, output sensor_value,
                  output scan_done, output power_x, output power_y, input ready);
  modport sink   (input valid, input sensor_index, input sensor_value,
                  input scan_done, input power_x, input power_y, output ready);
endinterface

>>> hdl/irdv_measure.sv
module irdv_measure
  import irdv_pkg::*;
#(
  parameter int SENSOR_COUNT = 12,
  parameter int TIME_BITS    = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic [COUNT_W-1:0]  changes_per_measure,
  irdv_sample_if.sink         samples,
  output logic                finish_valid,
  output finish_t             finish
);

  localparam int EXT_W = (TIME_BITS > CLAMP_W) ? TIME_BITS : CLAMP_W;

  logic [SENSOR_W-1:0]  current_sensor, current_sensor_next;
  logic                 measuring, measuring_next;
  logic                 last_level, last_level_next;
  logic [COUNT_W-1:0]   change_count, change_count_next;
  logic [TIME_BITS-1:0] low_time, low_time_next;

  logic                 accept;
  logic                 level;
  logic                 fin;
  logic                 scan_end;
  logic [EXT_W-1:0]     low_ext;
  logic [CLAMP_W-1:0]   low_clamped;

  assign samples.ready = adv;
  assign accept        = samples.valid && adv;

  // Track the current sensor: latch, count changes, add up low time
  always_comb begin
    level = 1'b0;
    if (current_sensor < SENSOR_W'(PIN_COUNT)) begin
      level = samples.pin_levels[current_sensor];
    end
    current_sensor_next = current_sensor;
    measuring_next      = measuring;
    last_level_next     = last_level;
    change_count_next   = change_count;
    low_time_next       = low_time;
    if (!measuring) begin
      last_level_next   = level;
      measuring_next    = 1'b1;
      change_count_next = '0;
      low_time_next     = '0;
      fin               = (changes_per_measure == '0);
    end else begin
      if (!last_level && !(&low_time)) begin
        low_time_next = low_time + 1'b1;
      end
      if (level != last_level) begin
        last_level_next   = level;
        change_count_next = change_count + 1'b1;
      end
      fin = !(change_count_next < changes_per_measure);
    end
    scan_end = ({1'b0, current_sensor} + 1'b1) >= (SENSOR_W + 1)'(SENSOR_COUNT);
    if (fin) begin
      measuring_next      = 1'b0;
      current_sensor_next = scan_end ? '0 : current_sensor + 1'b1;
    end
  end

  // Clamp the low time to the range the divider covers
  always_comb begin
    low_ext     = EXT_W'(low_time_next);
    low_clamped = (low_ext > EXT_W'(LOW_CLAMP)) ? LOW_CLAMP : low_ext[CLAMP_W-1:0];
  end

  // Update state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      current_sensor <= '0;
      measuring      <= 1'b0;
      last_level     <= 1'b0;
      change_count   <= '0;
      low_time       <= '0;
    end else if (accept) begin
      current_sensor <= current_sensor_next;
      measuring      <= measuring_next;
      last_level     <= last_level_next;
      change_count   <= change_count_next;
      low_time       <= low_time_next;
    end
  end

  // Hand a finished sensor to the scale stage
  always_ff @(posedge clk) begin
    if (rst) begin
      finish_valid <= 1'b0;
    end else if (adv) begin
      finish_valid <= accept && fin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      finish.sensor   <= current_sensor;
      finish.done     <= scan_end;
      finish.low_time <= low_clamped;
    end
  end

  a_sensor_in_ring: assert property (@(posedge clk) disable iff (rst)
    {1'b0, current_sensor} < (SENSOR_W + 1)'(SENSOR_COUNT))
    else $error("sensor position left the ring");

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    finish_valid && finish.done |-> finish.sensor == SENSOR_W'(SENSOR_COUNT - 1))
    else $error("scan ended on a sensor other than the last");

endmodule

>>> hdl/irdv_scale.sv
module irdv_scale
  import irdv_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    adv,
  input  logic    finish_valid,
  input  finish_t finish,
  output logic    term_valid,
  output term_t   term
);

  logic [CLAMP_W+RECIP_W-1:0]    quot_prod;
  logic                          value_valid;
  value_t                        value_q;
  logic signed [VALUE_W+WEIGHT_W:0] px, py;

  // Divide by 13 through the reciprocal
  assign quot_prod = CLAMP_W'(finish.low_time) * RECIP_W'(RECIP_13);

  // Weight the value by the sensor angle
  assign px = $signed({1'b0, value_q.value}) * cos_weight(value_q.sensor);
  assign py = $signed({1'b0, value_q.value}) * sin_weight(value_q.sensor);

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      value_valid <= 1'b0;
      term_valid  <= 1'b0;
    end else if (adv) begin
      value_valid <= finish_valid;
      term_valid  <= value_valid;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (adv) begin
      value_q.sensor <= finish.sensor;
      value_q.done   <= finish.done;
      value_q.value  <= quot_prod[RECIP_SHIFT +: VALUE_W];
      term.sensor    <= value_q.sensor;
      term.done      <= value_q.done;
      term.value     <= value_q.value;
      term.prod_x    <= px[PROD_W-1:0];
      term.prod_y    <= py[PROD_W-1:0];
    end
  end

endmodule

>>> hdl/irdv_accum.sv
module irdv_accum
  import irdv_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           term_valid,
  input  term_t          term,
  output logic           adv,
  irdv_result_if.source  results
);

  logic signed [POWER_W-1:0] sum_x, sum_y;
  logic signed [POWER_W:0]   raw_x, raw_y;
  logic signed [POWER_W-1:0] sat_x, sat_y;

  // Stall everything while a result beat waits
  assign adv = !results.valid || results.ready;

  // Add the terms with saturation at the signed 35-bit limits
  always_comb begin
    raw_x = {sum_x[POWER_W-1], sum_x} + (POWER_W + 1)'(term.prod_x);
    raw_y = {sum_y[POWER_W-1], sum_y} + (POWER_W + 1)'(term.prod_y);
    if (raw_x > SUM_MAX) begin
      sat_x = SUM_MAX[POWER_W-1:0];
    end else if (raw_x < SUM_MIN) begin
      sat_x = SUM_MIN[POWER_W-1:0];
    end else begin
      sat_x = raw_x[POWER_W-1:0];
    end
    if (raw_y > SUM_MAX) begin
      sat_y = SUM_MAX[POWER_W-1:0];
    end else if (raw_y < SUM_MIN) begin
      sat_y = SUM_MIN[POWER_W-1:0];
    end else begin
      sat_y = raw_y[POWER_W-1:0];
    end
  end

  // Hold the sums, clear them at the end of a scan
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0;
      sum_y <= '0;
    end else if (adv && term_valid) begin
      sum_x <= term.done ? '0 : sat_x;
      sum_y <= term.done ? '0 : sat_y;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (adv) begin
      results.valid <= term_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      results.sensor_index <= term.sensor;
      results.sensor_value <= term.value;
      results.scan_done    <= term.done;
      results.power_x      <= term.done ? sat_x : '0;
      results.power_y      <= term.done ? sat_y : '0;
    end
  end

  a_power_only_on_done: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.scan_done |-> results.power_x == '0 && results.power_y == '0)
    else $error("sums shown on a beat that does not end a scan");

  a_sums_cleared: assert property (@(posedge clk) disable iff (rst)
    adv && term_valid && term.done |=> sum_x == '0 && sum_y == '0)
    else $error("sums not cleared after the end of a scan");

endmodule

>>> hdl/ir_ring_pulse_direction_vector.sv
// Channel   Dir  Fields                                            Beat
// samples   in   pin_levels[11:0]                                  one microsecond tick
// results   out  sensor_index, sensor_value, scan_done,            one finished sensor
//                power_x, power_y
// apb       in   changes_per_measure at byte address 0             register write / read
//
// One sample beat is taken every cycle while no result beat waits; a finished sensor
// leaves through the measure, divide, weight and accumulate registers.
// Reset (rst, synchronous) clears the measurement state and sums and sets
// changes_per_measure to 10.
// A result beat that is not taken stalls the whole pipeline, the sample side included.
module ir_ring_pulse_direction_vector
  import irdv_pkg::*;
#(
  parameter int SENSOR_COUNT = 12,
  parameter int TIME_BITS    = 20
) (
  input  logic           clk,
  input  logic           rst,
  irdv_sample_if.sink    samples,
  irdv_result_if.source  results,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic [COUNT_W-1:0] changes_per_measure;
  logic               adv;
  logic               finish_valid;
  finish_t            finish;
  logic               term_valid;
  term_t              term;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHANGES) ? 32'(changes_per_measure) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      changes_per_measure <= CHANGES_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_CHANGES) begin
      changes_per_measure <= pwdata[COUNT_W-1:0];
    end
  end

  irdv_measure #(
    .SENSOR_COUNT (SENSOR_COUNT),
    .TIME_BITS    (TIME_BITS)
  ) u_measure (
    .clk                 (clk),
    .rst                 (rst),
    .adv                 (adv),
    .changes_per_measure (changes_per_measure),
    .samples             (samples),
    .finish_valid        (finish_valid),
    .finish              (finish)
  );

  irdv_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .finish_valid (finish_valid),
    .finish       (finish),
    .term_valid   (term_valid),
    .term         (term)
  );

  irdv_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .term_valid (term_valid),
    .term       (term),
    .adv        (adv),
    .results    (results)
  );

endmodule

>>> tb/irdv_direction_checker.sv
`timescale 1ns / 1ps
module irdv_direction_checker
  import irdv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  irdv_sample_if      smp,
  irdv_result_if      res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          reports
);

  localparam int RING         = 12;
  localparam int TIME_BITS    = 20;
  localparam int US_PER_COUNT = 13;
  localparam logic [TIME_BITS-1:0] LOW_US_MAX = '1;
  localparam longint VALUE_CAP = (1 << VALUE_W) - 1;
  localparam logic [2:0] CHANGES_ADDR = {REG_CHANGES, 2'b00};

  typedef struct packed {
    logic [SENSOR_W-1:0]      sensor;
    logic [VALUE_W-1:0]       value;
    logic                     done;
    logic signed [POWER_W-1:0] px;
    logic signed [POWER_W-1:0] py;
  } sensor_report_t;

  // cos and sin of 30 degree steps in Q1.14
  int cos_q14 [RING] = '{16384, 14189, 8192, 0, -8192, -14189,
                         -16384, -14189, -8192, 0, 8192, 14189};
  int sin_q14 [RING] = '{0, 8192, 14189, 16384, 14189, 8192,
                         0, -8192, -14189, -16384, -14189, -8192};

  logic [COUNT_W-1:0]   changes_cfg;
  logic [SENSOR_W-1:0]  cur_sensor;
  logic                 latched;
  logic                 last_lvl;
  logic [COUNT_W-1:0]   chg_cnt;
  logic [TIME_BITS-1:0] low_us;
  longint               acc_x;
  longint               acc_y;
  sensor_report_t       finished_q [$];
  int                   errors;
  int                   seen;

  function automatic longint clip_sum(input longint v);
    if (v > longint'(SUM_MAX)) clip_sum = longint'(SUM_MAX);
    else if (v < longint'(SUM_MIN)) clip_sum = longint'(SUM_MIN);
    else clip_sum = v;
  endfunction

  // Advance the sensor measurement by one tick, queue a report when a sensor closes
  task automatic measure_tick(input logic [PIN_COUNT-1:0] pins);
    logic           lvl;
    logic           closes;
    longint         value;
    int             k;
    sensor_report_t rep;
    lvl = (cur_sensor < PIN_COUNT) ? pins[cur_sensor] : 1'b0;
    if (!latched) begin
      last_lvl = lvl;
      latched  = 1'b1;
      chg_cnt  = '0;
      low_us   = '0;
      closes   = (changes_cfg == '0);
    end else begin
      if (!last_lvl && low_us != LOW_US_MAX) low_us = low_us + 1'b1;
      if (lvl != last_lvl) begin
        last_lvl = lvl;
        chg_cnt  = chg_cnt + 1'b1;
      end
      closes = (chg_cnt >= changes_cfg);
    end
    if (closes) begin
      latched = 1'b0;
      value = longint'(low_us) / US_PER_COUNT;
      if (value > VALUE_CAP) value = VALUE_CAP;
      k = cur_sensor % RING;
      acc_x = clip_sum(acc_x + value * cos_q14[k]);
      acc_y = clip_sum(acc_y + value * sin_q14[k]);
      rep.sensor = cur_sensor;
      rep.value  = value[VALUE_W-1:0];
      rep.done   = (cur_sensor + 1 >= RING);
      if (rep.done) begin
        rep.px = acc_x[POWER_W-1:0];
        rep.py = acc_y[POWER_W-1:0];
        acc_x = 0;
        acc_y = 0;
        cur_sensor = '0;
      end else begin
        rep.px = '0;
        rep.py = '0;
        cur_sensor = cur_sensor + 1'b1;
      end
      finished_q.push_back(rep);
    end
  endtask

  // Compare a result beat with the oldest queued report
  task automatic check_report();
    sensor_report_t want;
    seen++;
    if (finished_q.size() == 0) begin
      $error("unexpected result beat: sensor_index %0d", res.sensor_index);
      errors++;
    end else begin
      want = finished_q.pop_front();
      if (res.sensor_index !== want.sensor) begin
        $error("sensor_index: expected %0d, got %0d", want.sensor, res.sensor_index);
        errors++;
      end
      if (res.sensor_value !== want.value) begin
        $error("sensor_value: expected %0d, got %0d", want.value, res.sensor_value);
        errors++;
      end
      if (res.scan_done !== want.done) begin
        $error("scan_done: expected %0d, got %0d", want.done, res.scan_done);
        errors++;
      end
      if (res.power_x !== want.px) begin
        $error("power_x: expected %0d, got %0d", $signed(want.px), $signed(res.power_x));
        errors++;
      end
      if (res.power_y !== want.py) begin
        $error("power_y: expected %0d, got %0d", $signed(want.py), $signed(res.power_y));
        errors++;
      end
    end
  endtask

  // Watch result beats, sample beats and register writes
  always @(posedge clk) begin
    if (rst) begin
      changes_cfg = CHANGES_RESET;
      cur_sensor  = '0;
      latched     = 1'b0;
      last_lvl    = 1'b0;
      chg_cnt     = '0;
      low_us      = '0;
      acc_x       = 0;
      acc_y       = 0;
      errors      = 0;
      seen        = 0;
      finished_q.delete();
    end else begin
      if (res.valid && res.ready) check_report();
      if (smp.valid && smp.ready) measure_tick(smp.pin_levels);
      if (psel && penable && pwrite && pready && paddr == CHANGES_ADDR)
        changes_cfg = pwdata[COUNT_W-1:0];
    end
    fail_count <= errors;
    pending    <= finished_q.size();
    reports    <= seen;
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import irdv_pkg::*;

  localparam logic [2:0] CHANGES_ADDR = {REG_CHANGES, 2'b00};
  localparam int     RANDOM_ITEMS = 1400;
  localparam int     PHASE_ITEMS  = 200;
  localparam int     MIN_REPORTS  = 48;
  localparam int     HOLD_TICKS   = 200;
  localparam int     SETTLE       = 8;
  localparam longint CYCLE_LIMIT  = 200000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        send_gaps;
  logic        recv_stalls;
  int          stall_left;
  int          fail_count;
  int          pending;
  int          reports;
  longint      cycles;

  irdv_sample_if smp();
  irdv_result_if res();

  ir_ring_pulse_direction_vector uut (
    .clk,
    .rst,
    .samples (smp),
    .results (res),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  irdv_direction_checker chk (
    .clk,
    .rst,
    .smp,
    .res,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .pready,
    .fail_count,
    .pending,
    .reports
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Drop ready for a drawn number of cycles after each result beat
  always @(posedge clk) begin
    int next_stall;
    if (rst) begin
      stall_left <= 0;
      res.ready  <= 1'b0;
    end else begin
      if (res.valid && res.ready) next_stall = recv_stalls ? $urandom_range(7) : 0;
      else next_stall = (stall_left > 0) ? stall_left - 1 : 0;
      stall_left <= next_stall;
      res.ready  <= (next_stall == 0);
    end
  end

  // Offer one pin sample beat, after an optional gap, and hold it until taken
  task automatic send_tick(input logic [PIN_COUNT-1:0] pins);
    int gap;
    gap = send_gaps ? $urandom_range(7) : 0;
    if (gap != 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp.valid      <= 1'b1;
    smp.pin_levels <= pins;
    do @(posedge clk); while (!smp.ready);
  endtask

  // Stop sending, wait for every queued report, then let the pipeline empty
  task automatic drain_and_settle();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_changes(input logic [COUNT_W-1:0] n);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CHANGES_ADDR;
    pwdata  <= {{(32 - COUNT_W){1'b0}}, n};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly short pulses, some long runs to build up real values
  function automatic int pick_run();
    int r;
    r = $urandom_range(99);
    if (r < 65) pick_run = $urandom_range(3, 1);
    else if (r < 95) pick_run = $urandom_range(40, 4);
    else pick_run = $urandom_range(600, 41);
  endfunction

  // Pulse trains on all pins with random run lengths, some noise and partial flips
  task automatic random_phase(input int items);
    logic [PIN_COUNT-1:0] level_word;
    int                   run_left;
    level_word = PIN_COUNT'($urandom_range((1 << PIN_COUNT) - 1));
    run_left   = pick_run();
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(9) == 0) send_tick(PIN_COUNT'($urandom_range((1 << PIN_COUNT) - 1)));
      else send_tick(level_word);
      run_left--;
      if (run_left == 0) begin
        if ($urandom_range(4) == 0)
          level_word ^= PIN_COUNT'($urandom_range((1 << PIN_COUNT) - 1));
        else level_word = ~level_word;
        run_left = pick_run();
      end
    end
  endtask

  initial begin
    int                 items_sent;
    int                 phase;
    logic [COUNT_W-1:0] next_changes;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    smp.valid      = 1'b0;
    smp.pin_levels = '0;
    send_gaps      = 1'b0;
    recv_stalls    = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: sensor 0 closes after ten changes
    for (int i = 0; i < 11; i++) send_tick((i % 2 == 0) ? '0 : '1);
    drain_and_settle();

    // Zero changes: every latch tick closes a sensor with value 0
    write_changes('0);
    send_tick('1);
    send_tick('0);
    send_tick(12'h555);
    send_tick(12'hAAA);
    drain_and_settle();

    // Hold one sensor low for a long stretch to build up a large value
    write_changes(6'd1);
    send_tick('0);
    repeat (HOLD_TICKS) send_tick('0);
    send_tick('1);
    drain_and_settle();

    // Random phases, each under its own setting
    items_sent = 0;
    phase      = 0;
    while (items_sent < RANDOM_ITEMS || reports < MIN_REPORTS) begin
      case (phase)
        0:       next_changes = CHANGES_RESET;
        1:       next_changes = '1;
        2:       next_changes = '0;
        3:       next_changes = 6'd1;
        default: next_changes = ($urandom_range(7) == 0) ? COUNT_W'($urandom_range(63))
                                                         : COUNT_W'($urandom_range(12, 1));
      endcase
      write_changes(next_changes);
      send_gaps = ($urandom_range(3) != 0);
      recv_stalls <= ($urandom_range(3) != 0);
      random_phase(PHASE_ITEMS);
      items_sent += PHASE_ITEMS;
      drain_and_settle();
      phase++;
    end

    if (fail_count == 0 && pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Give up if the run hangs
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
hdl/irdv_pkg.sv
hdl/irdv_if.sv
hdl/irdv_measure.sv
hdl/irdv_scale.sv
hdl/irdv_accum.sv
hdl/ir_ring_pulse_direction_vector.sv
tb/irdv_direction_checker.sv
tb/tb.sv
